/* rtl/core/cpu_pkg.sv */
// shared constants, tables and types for the complex polar unit
package cpu_pkg;

   localparam int MaxStages     = 24;
   localparam int DefaultStages = 16;
   localparam int Guard         = 8;
   localparam int VecW          = 28;
   localparam int AngW          = 36;

   localparam logic [2:0] ModePolar = 3'd0;
   localparam logic [2:0] ModeRect  = 3'd1;
   localparam logic [2:0] ModeOfs   = 3'd2;
   localparam logic [2:0] ModeNorm  = 3'd3;
   localparam logic [2:0] ModeConj  = 3'd4;

   localparam logic [0:0] CsrMode   = 1'b0;
   localparam logic [0:0] CsrOffset = 1'b1;

   localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
   localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [AngW-1:0] TwoPiQ30  = 36'sd6746518852;
   localparam logic signed [31:0]     InvGain   = 32'sd652032874;
   localparam logic signed [VecW-1:0] UnitQ20   = 28'sd1048576;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      logic signed [AngW-1:0] t [MaxStages];
      t = '{36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
            36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
            36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
            36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
            36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
            36'sd1024, 36'sd512, 36'sd256, 36'sd128};
      return t[i];
   endfunction

   function automatic logic [15:0] sat16(input logic signed [AngW-1:0] v);
      if (v > 36'sd32767) return 16'h7fff;
      if (v < -36'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   // side data carried along the pipeline
   typedef struct packed {
      logic [2:0]  mode;
      logic        zero;
      logic [15:0] pass_re;
      logic [15:0] pass_im;
      logic signed [15:0] ofs;
   } side_type;

   // cordic working word
   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] z;
   } vec_type;

endpackage

/* rtl/core/cpu_cordic.sv */
// pipelined cordic, vectoring or rotation, one register per stage
module cpu_cordic #(
   parameter int STAGES = cpu_pkg::DefaultStages,
   parameter bit ROTATE = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cpu_pkg::vec_type  in_vec,
   input  cpu_pkg::side_type in_side,
   output logic              out_valid,
   output cpu_pkg::vec_type  out_vec,
   output cpu_pkg::side_type out_side
);
   import cpu_pkg::*;

   localparam int N = (STAGES > MaxStages) ? MaxStages : STAGES;

   logic     valid_ff [N+1];
   vec_type  vec_ff   [N+1];
   side_type side_ff  [N+1];

   always_comb begin
      valid_ff[0] = in_valid;
      vec_ff[0]   = in_vec;
      side_ff[0]  = in_side;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      vec_type vec_in;
      logic    up;
      always_comb begin
         up = ROTATE ? !vec_ff[i].z[AngW-1] : !vec_ff[i].y[VecW-1];
         vec_in = vec_ff[i];
         if (up ^ ROTATE) begin
            vec_in.x = vec_ff[i].x + (vec_ff[i].y >>> i);
            vec_in.y = vec_ff[i].y - (vec_ff[i].x >>> i);
         end else begin
            vec_in.x = vec_ff[i].x - (vec_ff[i].y >>> i);
            vec_in.y = vec_ff[i].y + (vec_ff[i].x >>> i);
         end
         if (up ^ ROTATE) vec_in.z = vec_ff[i].z + atan_entry(i);
         else vec_in.z = vec_ff[i].z - atan_entry(i);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (adv) begin
            vec_ff[i+1]  <= vec_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_vec   = vec_ff[N];
   assign out_side  = side_ff[N];
endmodule

/* rtl/core/complex_polar_unit_top.sv */
// top level of the complex polar unit
// throughput: one word per cycle; the whole pipeline advances unless the output is stalled
// reset: synchronous, clears valid bits, mode and radius offset
module complex_polar_unit_top #(
   parameter int CORDIC_STAGES = cpu_pkg::DefaultStages
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_in_re,
   input  logic signed [15:0] req_in_im,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_out_re,
   output logic signed [15:0] rsp_out_im,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import cpu_pkg::*;

   logic [2:0]         mode_ff;
   logic signed [15:0] ofs_ff;
   logic adv;

   // the chain moves whenever the output word is free or being taken
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModePolar;
         ofs_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMode:   mode_ff <= csr_data[2:0];
            CsrOffset: ofs_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // stage a: half plane fold for vectoring
   logic     a_valid_ff;
   vec_type  a_vec_ff;
   side_type a_side_ff;
   vec_type  a_vec_in;
   side_type a_side_in;
   always_comb begin
      logic signed [VecW-1:0] x, y;
      x = VecW'(req_in_re) <<< Guard;
      y = VecW'(req_in_im) <<< Guard;
      a_vec_in.z = '0;
      if (req_in_re[15]) begin
         a_vec_in.x = -x;
         a_vec_in.y = -y;
         a_vec_in.z = req_in_im[15] ? -PiQ30 : PiQ30;
      end else begin
         a_vec_in.x = x;
         a_vec_in.y = y;
      end
      a_side_in.mode    = mode_ff;
      a_side_in.zero    = (req_in_re == 16'sd0) && (req_in_im == 16'sd0);
      a_side_in.pass_re = req_in_re;
      a_side_in.pass_im = req_in_im;
      a_side_in.ofs     = ofs_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
      if (adv) begin
         a_vec_ff  <= a_vec_in;
         a_side_ff <= a_side_in;
      end
   end

   // vectoring cordic keeps the fold offset in z from the start
   logic     v_valid;
   vec_type  v_vec;
   side_type v_side;
   cpu_cordic #(.STAGES(CORDIC_STAGES), .ROTATE(1'b0)) u_vec (
      .clock, .reset, .adv,
      .in_valid(a_valid_ff), .in_vec(a_vec_ff), .in_side(a_side_ff),
      .out_valid(v_valid), .out_vec(v_vec), .out_side(v_side)
   );

   // stage b: gain multiply of magnitude
   logic     b_valid_ff;
   logic signed [59:0] b_prod_ff;
   logic signed [AngW-1:0] b_ang_ff;
   side_type b_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= v_valid;
      end
      if (adv) begin
         b_prod_ff <= 60'(v_vec.x) * 60'(InvGain);
         b_ang_ff  <= v_side.zero ? '0 : v_vec.z;
         b_side_ff <= v_side;
      end
   end

   // stage c: choose radius and angle for rotation, wrap angle, round the polar results
   logic signed [VecW-1:0] mag;
   assign mag = b_side_ff.zero ? '0 :
                VecW'((b_prod_ff + (60'sd1 <<< 29)) >>> 30);

   logic     c_valid_ff;
   logic signed [VecW-1:0] c_r_ff;
   logic signed [AngW-1:0] c_a_ff;
   side_type c_side_ff;
   logic signed [15:0] c_p0_ff, c_p1_ff;
   logic signed [VecW-1:0] c_r_in;
   logic signed [AngW-1:0] c_a_in;
   logic signed [15:0] c_p0_ff_in, c_p1_ff_in;
   always_comb begin
      logic signed [VecW-1:0] r;
      logic signed [AngW-1:0] a;
      r = VecW'(signed'(b_side_ff.pass_re)) <<< Guard;
      a = AngW'(signed'(b_side_ff.pass_im)) <<< 18;
      unique case (b_side_ff.mode)
         ModeOfs: begin
            r = mag + (VecW'(b_side_ff.ofs) <<< Guard);
            a = b_ang_ff;
         end
         ModeNorm: begin
            r = UnitQ20;
            a = b_ang_ff;
         end
         default: ;
      endcase
      c_p0_ff_in = sat16(AngW'((mag + VecW'(128)) >>> Guard));
      c_p1_ff_in = sat16((b_ang_ff + (36'sd1 <<< 17)) >>> 18);
      if (a > PiQ30) a = a - TwoPiQ30;
      else if (a < -PiQ30) a = a + TwoPiQ30;
      c_r_in = r;
      c_a_in = a;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
      if (adv) begin
         c_r_ff    <= c_r_in;
         c_a_ff    <= c_a_in;
         c_side_ff <= b_side_ff;
         c_p0_ff   <= c_p0_ff_in;
         c_p1_ff   <= c_p1_ff_in;
      end
   end

   // stage d: half plane fold, then gain multiply
   logic     d_valid_ff;
   logic signed [59:0] d_prod_ff;
   logic signed [AngW-1:0] d_a_ff;
   side_type d_side_ff;
   logic signed [15:0] d_p0_ff, d_p1_ff;
   logic signed [VecW-1:0] d_r_in;
   logic signed [AngW-1:0] d_a_in;
   always_comb begin
      logic signed [VecW-1:0] r;
      logic signed [AngW-1:0] a;
      r = c_r_ff;
      a = c_a_ff;
      if (a > HalfPiQ30) begin
         a = a - PiQ30;
         r = -r;
      end else if (a < -HalfPiQ30) begin
         a = a + PiQ30;
         r = -r;
      end
      d_r_in = r;
      d_a_in = a;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         d_prod_ff <= 60'(d_r_in) * 60'(InvGain);
         d_a_ff    <= d_a_in;
         d_side_ff <= c_side_ff;
         d_p0_ff   <= c_p0_ff;
         d_p1_ff   <= c_p1_ff;
      end
   end

   // stage e: rounding into rotation start vector
   logic     e_valid_ff;
   vec_type  e_vec_ff;
   side_type e_side_ff;
   logic signed [15:0] e_p0_ff, e_p1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
      if (adv) begin
         e_vec_ff.x <= VecW'((d_prod_ff + (60'sd1 <<< 29)) >>> 30);
         e_vec_ff.y <= '0;
         e_vec_ff.z <= d_a_ff;
         e_side_ff  <= d_side_ff;
         e_p0_ff    <= d_p0_ff;
         e_p1_ff    <= d_p1_ff;
      end
   end

   logic     r_valid;
   vec_type  r_vec;
   side_type r_side;
   cpu_cordic #(.STAGES(CORDIC_STAGES), .ROTATE(1'b1)) u_rot (
      .clock, .reset, .adv,
      .in_valid(e_valid_ff), .in_vec(e_vec_ff),
      .in_side(side_type'{mode: e_side_ff.mode, zero: e_side_ff.zero,
                          pass_re: e_p0_ff, pass_im: e_p1_ff, ofs: e_side_ff.ofs}),
      .out_valid(r_valid), .out_vec(r_vec), .out_side(r_side)
   );

   // polar results ride the rotation pipe in the pass fields
   logic [15:0] pre_ff, pim_ff;
   localparam int N = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
   logic [15:0] raw_re [N+1];
   logic [15:0] raw_im [N+1];
   assign raw_re[0] = e_side_ff.pass_re;
   assign raw_im[0] = e_side_ff.pass_im;
   for (genvar k = 0; k < N; k++) begin : g_raw
      always_ff @(posedge clock) begin
         if (adv) begin
            raw_re[k+1] <= raw_re[k];
            raw_im[k+1] <= raw_im[k];
         end
      end
   end

   // output stage
   logic        o_valid_ff;
   logic [15:0] o_re_ff, o_im_ff;
   logic [15:0] o_re_in, o_im_in;
   always_comb begin
      logic [16:0] neg_im;
      neg_im = -{raw_im[N][15], raw_im[N]};
      o_re_in = raw_re[N];
      o_im_in = raw_im[N];
      case (r_side.mode) inside
         ModePolar: begin
            o_re_in = r_side.pass_re;
            o_im_in = r_side.pass_im;
         end
         ModeRect, ModeOfs: begin
            o_re_in = sat16((AngW'(r_vec.x) + 36'sd128) >>> Guard);
            o_im_in = sat16((AngW'(r_vec.y) + 36'sd128) >>> Guard);
         end
         ModeNorm: begin
            o_re_in = r_side.zero ? '0 : sat16((AngW'(r_vec.x) + 36'sd128) >>> Guard);
            o_im_in = r_side.zero ? '0 : sat16((AngW'(r_vec.y) + 36'sd128) >>> Guard);
         end
         ModeConj: begin
            o_im_in = (raw_im[N] == 16'h8000) ? 16'h7fff : neg_im[15:0];
         end
         default: ;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= r_valid;
      end
      if (adv) begin
         o_re_ff <= o_re_in;
         o_im_ff <= o_im_in;
      end
   end
   assign pre_ff = o_re_ff;
   assign pim_ff = o_im_ff;

   assign rsp_valid  = o_valid_ff;
   assign rsp_out_re = pre_ff;
   assign rsp_out_im = pim_ff;
endmodule

/* verif/testbench.sv */
// self-checking testbench for the complex polar unit
`timescale 1ns / 1ps

module testbench;
   import cpu_pkg::*;

   localparam int Stages = (DefaultStages > MaxStages) ? MaxStages : DefaultStages;
   localparam longint Pi = 64'sd3373259426;
   localparam longint HalfPi = 64'sd1686629713;
   localparam longint TwoPi = 64'sd6746518852;
   localparam longint GainComp = 64'sd652032874;
   localparam int QuietLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_in_re = '0;
   logic signed [15:0] req_in_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_re;
   logic signed [15:0] rsp_out_im;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   longint atan_q30 [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

   logic [2:0] cfg_mode = ModePolar;
   logic signed [15:0] cfg_offset = '0;
   logic [31:0] expected_words [$];
   int send_idle = 0;
   int recv_idle = 0;
   int mismatches = 0;
   int quiet = 0;
   int holdoff_asks = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;

   complex_polar_unit_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint round_shift(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [15:0] clip16(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic void to_polar(input longint re, input longint im,
                                    output longint mag, output longint ang);
      longint x, y, z, base, dx, dy;
      z = 0;
      base = 0;
      if (re == 0 && im == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      x = re <<< Guard;
      y = im <<< Guard;
      if (x < 0) begin
         x = -x;
         y = -y;
         base = (im >= 0) ? Pi : -Pi;
      end
      for (int i = 0; i < Stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_q30[i];
         end else begin
            x -= dx; y += dy; z -= atan_q30[i];
         end
      end
      mag = round_shift(x * GainComp, 30);
      ang = z + base;
   endfunction

   function automatic logic [31:0] to_rect(input longint r, input longint a);
      longint x, y, z, dx, dy;
      y = 0;
      while (a > Pi) a -= TwoPi;
      while (a < -Pi) a += TwoPi;
      if (a > HalfPi) begin
         a -= Pi; r = -r;
      end else if (a < -HalfPi) begin
         a += Pi; r = -r;
      end
      x = round_shift(r * GainComp, 30);
      z = a;
      for (int i = 0; i < Stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q30[i];
         end else begin
            x += dx; y -= dy; z += atan_q30[i];
         end
      end
      return {clip16(round_shift(x, Guard)), clip16(round_shift(y, Guard))};
   endfunction

   function automatic logic [31:0] predict_word(input logic signed [15:0] in_re,
                                                input logic signed [15:0] in_im);
      longint re, im, mag, ang;
      re = in_re;
      im = in_im;
      case (cfg_mode)
         ModePolar: begin
            to_polar(re, im, mag, ang);
            return {clip16(round_shift(mag, Guard)), clip16(round_shift(ang, 18))};
         end
         ModeRect: return to_rect(re <<< Guard, im <<< 18);
         ModeOfs: begin
            to_polar(re, im, mag, ang);
            mag += longint'(cfg_offset) <<< Guard;
            return to_rect(mag, ang);
         end
         ModeNorm: begin
            if (re == 0 && im == 0) return 32'd0;
            to_polar(re, im, mag, ang);
            return to_rect(64'sd4096 <<< Guard, ang);
         end
         ModeConj: return {clip16(re), clip16(-im)};
         default: return {clip16(re), clip16(im)};
      endcase
   endfunction

   task automatic send_word(input logic [15:0] re, input logic [15:0] im);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_re <= re;
      req_in_im <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(predict_word(re, im));
   endtask

   task automatic write_reg(input logic index, input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CsrMode) cfg_mode = value[2:0];
      else cfg_offset = value;
   endtask

   function automatic logic [15:0] random_field();
      case ($urandom_range(3))
         0: return 16'($urandom_range(8192)) - 16'd4096;
         1: case ($urandom_range(5))
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'hffff;
               4: return 16'h1000;
               default: return 16'hf000;
            endcase
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic edge_words();
      logic [15:0] pts [13][2];
      pts = '{'{16'h0000, 16'h0000}, '{16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000},
              '{16'h8000, 16'h0000}, '{16'h0000, 16'h8000}, '{16'h1000, 16'h0000},
              '{16'h0000, 16'h1000}, '{16'hf000, 16'h0000}, '{16'hf000, 16'hffff},
              '{16'hffff, 16'h0000}, '{16'h0001, 16'hffff}, '{16'h7fff, 16'h8000},
              '{16'h8000, 16'h7fff}};
      foreach (pts[i]) send_word(pts[i][0], pts[i][1]);
   endtask

   task automatic random_words(input int count);
      repeat (count) send_word(random_field(), random_field());
   endtask

   task automatic test_polar();
      write_reg(CsrMode, 16'(ModePolar));
      edge_words();
   endtask

   task automatic test_rect();
      write_reg(CsrMode, 16'(ModeRect));
      edge_words();
      send_word(16'h1000, 16'h3244);
      send_word(16'h1000, 16'hcdbc);
   endtask

   task automatic test_offset();
      write_reg(CsrMode, 16'(ModeOfs));
      write_reg(CsrOffset, 16'h8000);
      edge_words();
      write_reg(CsrOffset, 16'h7fff);
      edge_words();
   endtask

   task automatic test_normalize();
      write_reg(CsrMode, 16'(ModeNorm));
      edge_words();
   endtask

   task automatic test_conjugate();
      write_reg(CsrMode, 16'(ModeConj));
      edge_words();
   endtask

   task automatic test_unused_modes();
      write_reg(CsrMode, 16'd5);
      random_words(4);
      write_reg(CsrMode, 16'd6);
      random_words(4);
      write_reg(CsrMode, 16'hffff);
      random_words(4);
   endtask

   task automatic test_random(input int phase);
      for (int m = 0; m < 5; m++) begin
         write_reg(CsrMode, 16'(m));
         if (m == 2) begin
            write_reg(CsrOffset, 16'h0000);
            random_words(25);
            write_reg(CsrOffset, 16'($urandom));
            random_words(30);
            write_reg(CsrOffset, 16'($urandom_range(8192)) - 16'd4096);
            random_words(30);
         end else begin
            if (m == 1 && phase == 1) holdoff_asks++;
            random_words(85);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_asks) begin
         holdoff_seen <= holdoff_asks;
         holdoff_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle;
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word re=%h im=%h", rsp_out_re, rsp_out_im);
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_re !== want[31:16] || rsp_out_im !== want[15:0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected re=%h im=%h, got re=%h im=%h",
                           want[31:16], want[15:0], rsp_out_re, rsp_out_im);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QuietLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_polar();
      test_rect();
      test_offset();
      test_normalize();
      test_conjugate();
      test_unused_modes();
      send_idle = 37;
      recv_idle = 66;
      test_random(0);
      send_idle = 66;
      recv_idle = 37;
      test_random(1);
      send_idle = 0;
      recv_idle = 0;
      test_random(2);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/cpu_pkg.sv
rtl/core/cpu_cordic.sv
rtl/core/complex_polar_unit_top.sv
verif/testbench.sv
